// ===== rtl/core/utf8_thai_script_ratio_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 Thai script ratio - assertion macros
// Shared concurrent assertion forms used by the ratio block's back end.
// ----------------------------------------------------------------------------
`ifndef UTF8_THAI_SCRIPT_RATIO_DEFINES_SVH
`define UTF8_THAI_SCRIPT_RATIO_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define U8TSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define U8TSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/u8tsr_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Thai script ratio - package
// Constants and shared types of the ratio block.
// ----------------------------------------------------------------------------
package u8tsr_pkg;

    // Configuration register indexes
    localparam logic REG_MAP_LOW  = 1'b0;
    localparam logic REG_MAP_HIGH = 1'b1;

    // Ignore map reset: whitespace, digits and ASCII punctuation
    localparam logic [63:0] MAP_LOW_RESET  = 64'hFFFF_FFFF_0000_3E00;
    localparam logic [63:0] MAP_HIGH_RESET = 64'h7800_0001_F800_0001;

    // Code point width and Thai block (U+0E00..U+0E7F is cp[20:7] == 0x1C)
    localparam int          CP_BITS    = 21;
    localparam logic [13:0] THAI_BLOCK = 14'h001C;

    // Result encoding
    localparam int          PCT_BITS   = 15;
    localparam int          OUT_CNT_W  = 16;
    localparam int          OUT_TDATA_W = 56;

    // Queue occupancy flags seen by the two sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_flags;

endpackage

// ===== rtl/core/u8tsr_front.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Thai script ratio - front end
// Decodes bytes leniently, classifies characters, keeps the per-text counters
// and pushes one summary record into the queue at each end of text.
// ----------------------------------------------------------------------------
module u8tsr_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // byte stream
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_byte,
    input  logic                         i_last,
    input  logic                         i_empty_text,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [63:0]                  i_cfg_data,
    // queue side: {foreign, sat, thai, ignored, chars}
    input  u8tsr_pkg::t_fifo_flags       i_flags,
    output logic                         o_push,
    output logic [3*COUNT_WIDTH+1:0]     o_entry
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    logic [63:0]                  r_map_lo, r_map_hi;
    logic [1:0]                   r_pend, n_pend;
    logic [u8tsr_pkg::CP_BITS-1:0] r_part, n_part;
    logic [COUNT_WIDTH-1:0]       r_char, n_char, r_ign, n_ign, r_thai, n_thai;
    logic                         r_foreign, n_foreign, r_sat, n_sat;

    logic                         accept, take, fin;
    logic [1:0]                   pe1;
    logic [u8tsr_pkg::CP_BITS-1:0] pa1, cls_cp;
    logic                         cls_en, is_ign, is_thai;

    assign o_ready = !i_flags.full;
    assign accept  = i_valid && o_ready;
    assign take    = accept && !i_empty_text;
    assign fin     = accept && (i_empty_text || i_last);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_lo <= u8tsr_pkg::MAP_LOW_RESET;
            r_map_hi <= u8tsr_pkg::MAP_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                u8tsr_pkg::REG_MAP_LOW:  r_map_lo <= i_cfg_data;
                u8tsr_pkg::REG_MAP_HIGH: r_map_hi <= i_cfg_data;
                default:                 r_map_lo <= r_map_lo;
            endcase
        end
    end

    // Decode: byte step first, then flush of a truncated sequence at end of text.
    // At most one character completes per transaction.
    always_comb begin
        pe1    = r_pend;
        pa1    = r_part;
        cls_en = 1'b0;
        cls_cp = u8tsr_pkg::CP_BITS'(i_byte);
        if (take) begin
            if (r_pend != 2'd0) begin
                pa1 = {r_part[u8tsr_pkg::CP_BITS-7:0], i_byte[5:0]};
                pe1 = r_pend - 2'd1;
                if (pe1 == 2'd0) begin
                    cls_en = 1'b1;
                    cls_cp = pa1;
                end
            end else begin
                priority if (!i_byte[7]) begin
                    cls_en = 1'b1;
                end else if (i_byte[7:5] == 3'b110) begin
                    pa1 = u8tsr_pkg::CP_BITS'(i_byte[4:0]);
                    pe1 = 2'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    pa1 = u8tsr_pkg::CP_BITS'(i_byte[3:0]);
                    pe1 = 2'd2;
                end else if (i_byte[7:3] == 5'b11110) begin
                    pa1 = u8tsr_pkg::CP_BITS'(i_byte[2:0]);
                    pe1 = 2'd3;
                end else begin
                    // stray continuation or invalid lead: one-byte character
                    cls_en = 1'b1;
                end
            end
        end
        // missing continuation bits are zero
        if (fin && pe1 != 2'd0) begin
            cls_en = 1'b1;
            unique case (pe1)
                2'd1:    cls_cp = {pa1[u8tsr_pkg::CP_BITS-7:0], 6'd0};
                2'd2:    cls_cp = {pa1[u8tsr_pkg::CP_BITS-13:0], 12'd0};
                default: cls_cp = {pa1[u8tsr_pkg::CP_BITS-19:0], 18'd0};
            endcase
        end
    end

    // Classification
    always_comb begin
        is_ign  = (cls_cp[u8tsr_pkg::CP_BITS-1:7] == '0) &&
                  (cls_cp[6] ? r_map_hi[cls_cp[5:0]] : r_map_lo[cls_cp[5:0]]);
        is_thai = (cls_cp[u8tsr_pkg::CP_BITS-1:7] == u8tsr_pkg::THAI_BLOCK);
    end

    // Saturating counters
    always_comb begin
        n_char    = r_char;
        n_ign     = r_ign;
        n_thai    = r_thai;
        n_foreign = r_foreign;
        n_sat     = r_sat;
        if (cls_en) begin
            if (r_char != CNT_MAX) n_char = r_char + 1'b1;
            else                   n_sat  = 1'b1;
            priority if (is_ign) begin
                if (r_ign != CNT_MAX) n_ign = r_ign + 1'b1;
                else                  n_sat = 1'b1;
            end else if (is_thai) begin
                if (r_thai != CNT_MAX) n_thai = r_thai + 1'b1;
                else                   n_sat  = 1'b1;
            end else begin
                n_foreign = 1'b1;
            end
        end
        n_pend = pe1;
        n_part = pa1;
    end

    // Summary record for the back end
    assign o_push  = fin;
    assign o_entry = {n_foreign, n_sat, n_thai, n_ign, n_char};

    // Per-text state, cleared at end of text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || fin) begin
            r_pend    <= '0;
            r_part    <= '0;
            r_char    <= '0;
            r_ign     <= '0;
            r_thai    <= '0;
            r_foreign <= 1'b0;
            r_sat     <= 1'b0;
        end else begin
            r_pend    <= n_pend;
            r_part    <= n_part;
            r_char    <= n_char;
            r_ign     <= n_ign;
            r_thai    <= n_thai;
            r_foreign <= n_foreign;
            r_sat     <= n_sat;
        end
    end

endmodule

// ===== rtl/core/u8tsr_fifo.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Thai script ratio - summary queue
// Two-entry queue between the front end and the divider back end.
// ----------------------------------------------------------------------------
module u8tsr_fifo #(
    parameter int WIDTH = 50
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [WIDTH-1:0]       i_data,
    input  logic                   i_pop,
    output logic [WIDTH-1:0]       o_data,
    output u8tsr_pkg::t_fifo_flags o_flags
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, r_rd;
    logic [1:0]       r_cnt;

    assign o_flags.full  = (r_cnt == 2'd2);
    assign o_flags.empty = (r_cnt == 2'd0);
    assign o_data        = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/u8tsr_back.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Thai script ratio - back end
// Takes one summary record, clamps the counts, divides 25600*thai by counted,
// one quotient bit per cycle (skipped when counted is zero), and holds the result until it is taken.
// ----------------------------------------------------------------------------
`include "utf8_thai_script_ratio_defines.svh"

module u8tsr_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  u8tsr_pkg::t_fifo_flags        i_flags,
    input  logic [3*COUNT_WIDTH+1:0]      i_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [u8tsr_pkg::OUT_TDATA_W-1:0] o_data
);

    localparam int DW = COUNT_WIDTH + u8tsr_pkg::PCT_BITS;
    localparam int MW = (COUNT_WIDTH > u8tsr_pkg::OUT_CNT_W) ? COUNT_WIDTH
                                                              : u8tsr_pkg::OUT_CNT_W;
    localparam logic [MW-1:0] OUT_MAX = MW'({u8tsr_pkg::OUT_CNT_W{1'b1}});
    localparam logic [3:0]    LAST_STEP = 4'(u8tsr_pkg::PCT_BITS - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUB  = 6'b000010,
        ST_CLMP = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_back_state;

    t_back_state                     r_state;
    logic [COUNT_WIDTH-1:0]          r_char, r_ign, r_thai, r_cnt;
    logic                            r_foreign, r_sat, r_ovf;
    logic [u8tsr_pkg::OUT_CNT_W-1:0] r_othai, r_ocnt;
    logic [DW-1:0]                   r_rem, r_dvs;
    logic [u8tsr_pkg::PCT_BITS-1:0]  r_quot;
    logic [3:0]                      r_step;
    logic                            ge;
    logic [COUNT_WIDTH-1:0]          thai_c;

    assign o_pop   = (r_state == ST_IDLE) && !i_flags.empty;
    assign o_valid = (r_state == ST_OUT);
    assign o_data  = {{(u8tsr_pkg::OUT_TDATA_W - 49){1'b0}}, r_ovf, r_ocnt, r_othai,
                      r_quot, !r_foreign};
    assign ge      = (r_rem >= r_dvs);
    // thai never exceeds counted
    assign thai_c  = (r_thai > r_cnt) ? r_cnt : r_thai;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: if (!i_flags.empty) r_state <= ST_SUB;
                ST_SUB:  r_state <= ST_CLMP;
                ST_CLMP: r_state <= ST_MUL;
                ST_MUL:  r_state <= (r_cnt == '0) ? ST_OUT : ST_DIV;
                ST_DIV:  if (r_step == 4'd0) r_state <= ST_OUT;
                ST_OUT:  if (i_ready) r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_char    <= i_entry[COUNT_WIDTH-1:0];
                r_ign     <= i_entry[2*COUNT_WIDTH-1:COUNT_WIDTH];
                r_thai    <= i_entry[3*COUNT_WIDTH-1:2*COUNT_WIDTH];
                r_sat     <= i_entry[3*COUNT_WIDTH];
                r_foreign <= i_entry[3*COUNT_WIDTH+1];
            end
            ST_SUB: begin
                // non-ignored characters
                r_cnt <= (r_char >= r_ign) ? (r_char - r_ign) : '0;
            end
            ST_CLMP: begin
                // thai never exceeds counted; outputs clamp to 16 bits
                r_thai  <= thai_c;
                r_othai <= (MW'(thai_c) > OUT_MAX) ? '1 : u8tsr_pkg::OUT_CNT_W'(thai_c);
                r_ocnt  <= (MW'(r_cnt) > OUT_MAX) ? '1 : u8tsr_pkg::OUT_CNT_W'(r_cnt);
                r_ovf   <= r_sat || (MW'(r_cnt) > OUT_MAX);
            end
            ST_MUL: begin
                // 25600 = 2^14 + 2^13 + 2^10
                r_rem  <= (DW'(r_thai) << 14) + (DW'(r_thai) << 13) + (DW'(r_thai) << 10);
                r_dvs  <= DW'(r_cnt) << LAST_STEP;
                r_step <= LAST_STEP;
                r_quot <= '0;
            end
            ST_DIV: begin
                if (ge) r_rem <= r_rem - r_dvs;
                r_quot <= {r_quot[u8tsr_pkg::PCT_BITS-2:0], ge};
                r_dvs  <= r_dvs >> 1;
                r_step <= r_step - 4'd1;
            end
            ST_OUT: begin
                r_quot <= r_quot;
            end
            default: begin
                r_quot <= r_quot;
            end
        endcase
    end

    `U8TSR_ASSERT_SAME(a_pop_idle, i_clk, i_rst_n, o_pop, (r_state == ST_IDLE) && !i_flags.empty, "queue popped outside idle")
    `U8TSR_ASSERT_SAME(a_pct_range, i_clk, i_rst_n, o_valid, r_quot <= 15'd25600, "percentage above 100")
    `U8TSR_ASSERT_SAME(a_zero_count, i_clk, i_rst_n, o_valid && (r_ocnt == '0), r_quot == '0, "nonzero percentage with no counted characters")
    `U8TSR_ASSERT_NEXT(a_sub_clmp, i_clk, i_rst_n, r_state == ST_SUB, r_state == ST_CLMP, "subtract not followed by clamp")

endmodule

// ===== rtl/core/utf8_thai_script_ratio.sv =====
// ----------------------------------------------------------------------------
// UTF-8 Thai script ratio - top level
// Byte-stream UTF-8 decoder that reports the Thai share of each text.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle on the slave stream; a text ends with
// tlast on its final byte, or with tuser (empty text) on a transaction that
// carries no byte. With the back end free, each ended text gives one result
// transaction once its final transaction is accepted: the summary is popped,
// the ignored count is subtracted and the counts clamped, 25600*thai is
// formed, and the shift-subtract divider yields one quotient bit per cycle.
// A text with no counted characters skips the divider. A two-entry summary
// queue sits between decoder and divider, so bytes keep flowing while a
// result is computed or waits to be taken; only when two ended texts are
// already queued does tready drop. Configuration writes are always accepted
// and take effect on the next transaction.
// ----------------------------------------------------------------------------
module utf8_thai_script_ratio #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,   // last_byte
    input  logic        s_axis_tuser,   // empty_text
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] all_thai, [15:1] thai_percent, [31:16] thai_chars,
    // [47:32] counted_chars, [48] count_overflow, [55:49] zero
    output logic [55:0] m_axis_tdata,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int EW = 3 * COUNT_WIDTH + 2;

    u8tsr_pkg::t_fifo_flags flags;
    logic                   push, pop;
    logic [EW-1:0]          entry_in, entry_out;

    assign o_cfg_ready = 1'b1;

    u8tsr_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_empty_text (s_axis_tuser),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_flags      (flags),
        .o_push       (push),
        .o_entry      (entry_in)
    );

    u8tsr_fifo #(.WIDTH(EW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (entry_in),
        .i_pop   (pop),
        .o_data  (entry_out),
        .o_flags (flags)
    );

    u8tsr_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .i_entry (entry_out),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule
